// ----- sv/assert_macros.svh -----
// Assertion macros used by the RTL of the LRU page tracker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`endif

// ----- sv/lrupt_pkg.sv -----
// Package: constants and command codes of the LRU page tracker.
package lrupt_pkg;

   localparam int CAPACITY_DEFAULT  = 16;
   localparam int PAGE_BITS_DEFAULT = 8;
   localparam int PAGE_FIELD_BITS   = 8;

   localparam logic CMD_TOUCH  = 1'b0;
   localparam logic CMD_INSERT = 1'b1;

endpackage

// ----- sv/lru_page_tracker_top.sv -----
// Top level: LRU page tracker with a CAM of pages and per-slot recency ranks.
//
//  channel   direction  ports                                           handshake
//  req       in         req_command, req_page_number                    req_valid/req_ready
//  rsp       out        rsp_hit, rsp_evicted, rsp_evicted_page          rsp_valid/rsp_ready
//
// One transaction per cycle sustained while rsp_ready is held high. A request is captured in the
// input register when it is accepted; once the output register is free, all slots are compared
// at once, ranks and slots are updated and the result is loaded into the output register, which
// raises rsp_valid. The per-cycle work is bounded by the CAM compare plus the rank update.
// Synchronous reset empties the store; no clearing pass is needed.
// A stalled rsp holds the output register; the input register then fills and
// req_ready drops until rsp_ready returns.
`include "assert_macros.svh"

module lru_page_tracker_top #(
   parameter int CAPACITY         = lrupt_pkg::CAPACITY_DEFAULT,
   parameter int PAGE_NUMBER_BITS = lrupt_pkg::PAGE_BITS_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic                                 req_command,
   input  logic [lrupt_pkg::PAGE_FIELD_BITS-1:0] req_page_number,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic                                 rsp_hit,
   output logic                                 rsp_evicted,
   output logic [lrupt_pkg::PAGE_FIELD_BITS-1:0] rsp_evicted_page
);
   import lrupt_pkg::*;

   localparam int PB     = PAGE_NUMBER_BITS;
   localparam int FB     = PAGE_FIELD_BITS;
   localparam int RANK_W = $clog2(CAPACITY);
   localparam int OCC_W  = $clog2(CAPACITY + 1);
   localparam logic [RANK_W-1:0] RANK_LAST = RANK_W'(CAPACITY - 1);
   localparam logic [OCC_W-1:0]  OCC_FULL  = OCC_W'(CAPACITY);
   localparam logic [RANK_W:0]   RANK_NONE = (RANK_W + 1)'(CAPACITY);

   // input register
   logic          in_valid_ff;
   logic          in_cmd_ff;
   logic [PB-1:0] in_page_ff;

   // tracker state
   logic [PB-1:0]     entry_page_ff  [CAPACITY];
   logic [CAPACITY-1:0] entry_valid_ff;
   logic [RANK_W-1:0] recency_rank_ff [CAPACITY];
   logic [OCC_W-1:0]  occupancy_ff;

   // output register
   logic          rsp_valid_ff;
   logic          rsp_hit_ff;
   logic          rsp_evicted_ff;
   logic [FB-1:0] rsp_evicted_page_ff;

   // next-state values
   logic [CAPACITY-1:0] entry_valid_in;
   logic [RANK_W-1:0]   recency_rank_in [CAPACITY];
   logic [OCC_W-1:0]    occupancy_in;
   logic                rsp_hit_in;
   logic                rsp_evicted_in;
   logic [FB-1:0]       rsp_evicted_page_in;

   logic                advance;
   logic [PB-1:0]       req_page_masked;
   logic [PB+FB-1:0]    req_page_wide;
   logic [PB+FB-1:0]    victim_page_wide;
   logic [CAPACITY-1:0] match_vec;
   logic [CAPACITY-1:0] victim_vec;
   logic [CAPACITY-1:0] victim_oh;
   logic [CAPACITY-1:0] free_vec;
   logic [CAPACITY-1:0] free_oh;
   logic [CAPACITY-1:0] target_oh;
   logic [CAPACITY-1:0] page_write;
   logic [RANK_W-1:0]   hit_rank;
   logic [PB-1:0]       victim_page;
   logic [RANK_W:0]     old_rank;
   logic                is_hit;
   logic                is_full;
   logic                do_insert;

   // handshake: the input register moves on whenever the output register is free
   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   // page number kept in PAGE_NUMBER_BITS bits
   assign req_page_wide   = {{PB{1'b0}}, req_page_number};
   assign req_page_masked = req_page_wide[PB-1:0];

   // CAM compare, victim and free-slot search
   always_comb begin
      hit_rank    = '0;
      victim_page = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         match_vec[i]  = entry_valid_ff[i] && (entry_page_ff[i] == in_page_ff);
         victim_vec[i] = entry_valid_ff[i] && (recency_rank_ff[i] == RANK_LAST);
         free_vec[i]   = !entry_valid_ff[i];
      end
      victim_oh = victim_vec & (~victim_vec + CAPACITY'(1));
      free_oh   = free_vec & (~free_vec + CAPACITY'(1));
      for (int i = 0; i < CAPACITY; i++) begin
         hit_rank    = hit_rank | (match_vec[i] ? recency_rank_ff[i] : '0);
         victim_page = victim_page | (victim_oh[i] ? entry_page_ff[i] : '0);
      end
   end

   assign is_hit    = |match_vec;
   assign is_full   = (occupancy_ff == OCC_FULL);
   assign do_insert = !is_hit && (in_cmd_ff == CMD_INSERT);
   // a touch miss ages nothing
   assign old_rank  = is_hit ? {1'b0, hit_rank} : (do_insert ? RANK_NONE : '0);

   always_comb begin
      if (is_hit) begin
         target_oh = match_vec;
      end else if (do_insert) begin
         target_oh = is_full ? victim_oh : free_oh;
      end else begin
         target_oh = '0;
      end
   end

   // only misses that insert write a page
   assign page_write = do_insert ? target_oh : '0;

   // promote: target goes to rank 0, younger valid slots age by one
   always_comb begin
      for (int i = 0; i < CAPACITY; i++) begin
         if (target_oh[i]) begin
            recency_rank_in[i] = '0;
         end else if (entry_valid_ff[i] && ({1'b0, recency_rank_ff[i]} < old_rank)) begin
            recency_rank_in[i] = recency_rank_ff[i] + RANK_W'(1);
         end else begin
            recency_rank_in[i] = recency_rank_ff[i];
         end
      end
   end

   always_comb begin
      entry_valid_in = entry_valid_ff | page_write;
      occupancy_in   = occupancy_ff;
      if (do_insert && !is_full) begin
         occupancy_in = occupancy_ff + OCC_W'(1);
      end
   end

   assign victim_page_wide    = {{FB{1'b0}}, victim_page};
   assign rsp_hit_in          = is_hit;
   assign rsp_evicted_in      = do_insert && is_full;
   assign rsp_evicted_page_in = rsp_evicted_in ? victim_page_wide[FB-1:0] : '0;

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         entry_valid_ff <= '0;
         occupancy_ff   <= '0;
         for (int i = 0; i < CAPACITY; i++) begin
            recency_rank_ff[i] <= '0;
         end
      end else begin
         if (req_ready) begin
            in_valid_ff <= req_valid;
         end
         if (advance) begin
            rsp_valid_ff   <= 1'b1;
            entry_valid_ff <= entry_valid_in;
            occupancy_ff   <= occupancy_in;
            for (int i = 0; i < CAPACITY; i++) begin
               recency_rank_ff[i] <= recency_rank_in[i];
            end
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_cmd_ff  <= req_command;
         in_page_ff <= req_page_masked;
      end
      if (advance) begin
         rsp_hit_ff          <= rsp_hit_in;
         rsp_evicted_ff      <= rsp_evicted_in;
         rsp_evicted_page_ff <= rsp_evicted_page_in;
         for (int i = 0; i < CAPACITY; i++) begin
            if (page_write[i]) begin
               entry_page_ff[i] <= in_page_ff;
            end
         end
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_hit          = rsp_hit_ff;
   assign rsp_evicted      = rsp_evicted_ff;
   assign rsp_evicted_page = rsp_evicted_page_ff;

   `ASSERT_IMPLIES(a_occ_matches_valid, clock, reset, 1'b1, ($countones(entry_valid_ff) == 32'(occupancy_ff)))
   `ASSERT_IMPLIES(a_occ_bounded, clock, reset, 1'b1, (occupancy_ff <= OCC_FULL))
   `ASSERT_IMPLIES(a_evict_not_hit, clock, reset, rsp_valid_ff && rsp_evicted_ff, !rsp_hit_ff)
   `ASSERT_IMPLIES(a_target_onehot, clock, reset, advance, $onehot0(target_oh))
   `ASSERT_NEXT(a_evict_stays_full, clock, reset, advance && rsp_evicted_in, (occupancy_ff == OCC_FULL))

endmodule
